// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle.
`define WPP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Consequent checked in the following cycle.
`define WPP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: hdl/wpp_pkg.sv
// ----------------------------------------------------------------------------
// wpp_pkg
// Constants, types and helpers shared by the peak pyramid modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpp_pkg;

  localparam int unsigned MaxLevels       = 24;
  localparam int unsigned MaxBucketFrames = 4096;

  localparam int unsigned SampW  = 16;
  localparam int unsigned MagW   = 15;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned LvlW   = 5;
  localparam int unsigned IdxW   = 24;
  localparam int unsigned ValW   = 8;

  localparam int unsigned LvlIdxW   = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;
  localparam int unsigned FrameCntW = (MaxBucketFrames > 1) ? $clog2(MaxBucketFrames) : 1;
  localparam int unsigned SizeW     = FrameCntW + 1;
  localparam int unsigned ValBitW   = $clog2(ValW);

  localparam int unsigned MulW      = 16;
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned SqrtShift = 13;

  localparam logic [CfgW-1:0] BucketReset  = CfgW'(512);
  localparam logic [MulW-1:0] CompandScale = MulW'(65025);
  localparam logic [MagW-1:0] FullMag      = {MagW{1'b1}};

  typedef struct packed {
    logic [LvlW-1:0] level;
    logic [IdxW-1:0] index;
    logic [ValW-1:0] value;
  } wpp_res_t;

  typedef struct packed {
    logic push;
    logic close;
    logic last;
  } wpp_ob_req_t;

  function automatic logic [MagW-1:0] wpp_mag(input logic signed [SampW-1:0] s);
    logic [SampW-1:0] n;
    n = s[SampW-1] ? SampW'(-s) : SampW'(s);
    return (n > SampW'(FullMag)) ? FullMag : n[MagW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/waveform_peak_pyramid.sv
// ----------------------------------------------------------------------------
// waveform_peak_pyramid
// Stereo peak envelope with a max pyramid of square-root companded levels.
//
//   channel  direction  handshake                 word
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_bucket_frames_i
//   in       in         in_valid_i / in_ready_o    left/right sample, end_of_clip
//   out      out        out_valid_o / out_ready_i  level, bucket_index, peak, last
//
// A frame that leaves its bucket open only updates the running peak and frame
// count and leaves the input ready. A closing frame holds the input busy while
// the compander runs (one shared 16x16 multiplier, eight search steps) and the
// level sequencer emits one word per level, scans the flush levels at end of
// clip and closes.
// Reset is asynchronous and immediate; no clearing pass.
// A stalled output holds two words, then the level sequencer waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module waveform_peak_pyramid import wpp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgW-1:0]         cfg_bucket_frames_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SampW-1:0] left_sample_i,
  input  logic signed [SampW-1:0] right_sample_i,
  input  logic                    end_of_clip_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [LvlW-1:0]         level_o,
  output logic [IdxW-1:0]         bucket_index_o,
  output logic [ValW-1:0]         peak_value_o,
  output logic                    last_o
);

  logic [CfgW-1:0]      cfg_q;
  logic [MagW-1:0]      peak_q;
  logic [FrameCntW-1:0] cnt_q;
  logic                 busy_q;
  logic                 end_q;

  logic [SizeW-1:0] size;
  logic [MagW-1:0]  mag_l;
  logic [MagW-1:0]  mag_r;
  logic [MagW-1:0]  peak_lr;
  logic [MagW-1:0]  peak_new;
  logic             accept;
  logic             close;

  logic            cmp_done;
  logic [ValW-1:0] cmp_value;
  wpp_ob_req_t     ob_req;
  wpp_res_t        pyr_res;
  logic            ob_ready;
  logic            pyr_idle;
  logic            pyr_done;
  wpp_res_t        out_res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_q == '0) begin
      size = SizeW'(1);
    end else if (32'(cfg_q) > 32'(MaxBucketFrames)) begin
      size = SizeW'(MaxBucketFrames);
    end else begin
      size = SizeW'(cfg_q);
    end
  end

  assign mag_l    = wpp_mag(left_sample_i);
  assign mag_r    = wpp_mag(right_sample_i);
  assign peak_lr  = (mag_l > mag_r) ? mag_l : mag_r;
  assign peak_new = (peak_lr > peak_q) ? peak_lr : peak_q;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign close      = ((SizeW'(cnt_q) + 1'b1) >= size) || end_of_clip_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= BucketReset;
      peak_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      end_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_bucket_frames_i;
      end
      if (accept) begin
        end_q <= end_of_clip_i;
        if (close) begin
          peak_q <= '0;
          cnt_q  <= '0;
          busy_q <= 1'b1;
        end else begin
          peak_q <= peak_new;
          cnt_q  <= cnt_q + 1'b1;
        end
      end else if (pyr_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  wpp_compand u_compand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && close),
    .peak_i  (peak_new),
    .done_o  (cmp_done),
    .value_o (cmp_value)
  );

  wpp_pyramid u_pyramid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmp_done),
    .value_i    (cmp_value),
    .end_i      (end_q),
    .ob_ready_i (ob_ready),
    .ob_req_o   (ob_req),
    .res_o      (pyr_res),
    .idle_o     (pyr_idle),
    .done_o     (pyr_done)
  );

  wpp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (ob_req),
    .res_i       (pyr_res),
    .ready_o     (ob_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res),
    .out_last_o  (last_o)
  );

  assign level_o        = out_res.level;
  assign bucket_index_o = out_res.index;
  assign peak_value_o   = out_res.value;

  `WPP_ASSERT_IMP(a_compand_done_while_busy, cmp_done, busy_q && pyr_idle)
  `WPP_ASSERT_IMP(a_idle_pyramid_when_ready, in_ready_o, pyr_idle)

endmodule

`default_nettype wire

// File: hdl/wpp_compand.sv
// ----------------------------------------------------------------------------
// wpp_compand
// Square-root compander: one shared multiplier forms 65025*peak, then a
// bit-by-bit search finds the largest n with (2n-1)^2 * 8192 <= 65025*peak.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wpp_compand import wpp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MagW-1:0] peak_i,
  output logic            done_o,
  output logic [ValW-1:0] value_o
);

  typedef enum logic [1:0] {StIdle, StRhs, StSearch, StDone} state_e;

  state_e               state_q;
  logic [MagW-1:0]      p_q;
  logic [ProdW-1:0]     rhs_q;
  logic [ValW-1:0]      v_q;
  logic [ValBitW-1:0]   bit_q;

  logic [ValW-1:0]            trial;
  logic [ValW:0]              odd;
  logic [MulW-1:0]            mul_a;
  logic [MulW-1:0]            mul_b;
  logic [ProdW-1:0]           prod;
  logic [ProdW+SqrtShift-1:0] sq_scaled;
  logic                       fits;

  assign trial = v_q | (ValW'(1) << bit_q);
  assign odd   = {trial, 1'b0} - (ValW+1)'(1);

  always_comb begin
    if (state_q == StRhs) begin
      mul_a = CompandScale;
      mul_b = MulW'(p_q);
    end else begin
      mul_a = MulW'(odd);
      mul_b = MulW'(odd);
    end
  end

  assign prod      = mul_a * mul_b;
  assign sq_scaled = {prod, {SqrtShift{1'b0}}};
  assign fits      = sq_scaled <= (ProdW+SqrtShift)'(rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      p_q     <= '0;
      rhs_q   <= '0;
      v_q     <= '0;
      bit_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            p_q     <= peak_i;
            state_q <= StRhs;
          end
        end
        StRhs: begin
          rhs_q   <= prod;
          v_q     <= '0;
          bit_q   <= ValBitW'(ValW - 1);
          state_q <= StSearch;
        end
        StSearch: begin
          if (fits) begin
            v_q <= trial;
          end
          if (bit_q == '0) begin
            state_q <= StDone;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        StDone: begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign done_o  = (state_q == StDone);
  assign value_o = v_q;

  `WPP_ASSERT_NXT(a_search_ends_in_done, (state_q == StSearch) && (bit_q == '0), done_o)
  `WPP_ASSERT_NXT(a_start_only_when_idle, start_i && (state_q == StIdle), state_q == StRhs)

endmodule

`default_nettype wire

// File: hdl/wpp_pyramid.sv
// ----------------------------------------------------------------------------
// wpp_pyramid
// Level store and sequencer: inserts one value per unstalled emission cycle,
// merges pairs upward by max, and on end of clip flushes odd pending values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wpp_pyramid import wpp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ValW-1:0] value_i,
  input  logic            end_i,
  input  logic            ob_ready_i,
  output wpp_ob_req_t     ob_req_o,
  output wpp_res_t        res_o,
  output logic            idle_o,
  output logic            done_o
);

  typedef enum logic [1:0] {StIdle, StInsert, StFlush, StClose} state_e;

  state_e               state_q;
  logic [LvlIdxW-1:0]   lvl_q;
  logic [LvlIdxW-1:0]   fl_q;
  logic [ValW-1:0]      val_q;
  logic                 end_q;
  logic [MaxLevels-1:0] pend_vld_q;
  logic [ValW-1:0]      pend_val_q [MaxLevels];
  logic [IdxW-1:0]      cnt_q      [MaxLevels];

  logic [IdxW-1:0] cur_cnt;
  logic [ValW-1:0] cur_pv;
  logic [ValW-1:0] merged;
  logic            top_lvl;
  logic            fl_stop;
  logic            store;
  state_e          ret_state;

  assign cur_cnt   = cnt_q[lvl_q];
  assign cur_pv    = pend_val_q[lvl_q];
  assign merged    = (cur_pv > val_q) ? cur_pv : val_q;
  assign top_lvl   = (lvl_q == LvlIdxW'(MaxLevels - 1));
  assign fl_stop   = (fl_q == LvlIdxW'(MaxLevels - 1)) || (cnt_q[fl_q] <= IdxW'(1));
  assign ret_state = end_q ? StFlush : StClose;
  assign store     = (state_q == StInsert) && ob_ready_i && !top_lvl && !pend_vld_q[lvl_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      lvl_q      <= '0;
      fl_q       <= '0;
      val_q      <= '0;
      end_q      <= 1'b0;
      pend_vld_q <= '0;
      for (int i = 0; i < MaxLevels; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            lvl_q   <= '0;
            fl_q    <= '0;
            val_q   <= value_i;
            end_q   <= end_i;
            state_q <= StInsert;
          end
        end
        StInsert: begin
          if (ob_ready_i) begin
            cnt_q[lvl_q] <= cur_cnt + 1'b1;
            if (top_lvl) begin
              state_q <= ret_state;
            end else if (pend_vld_q[lvl_q]) begin
              val_q             <= merged;
              pend_vld_q[lvl_q] <= 1'b0;
              lvl_q             <= lvl_q + 1'b1;
            end else begin
              pend_vld_q[lvl_q] <= 1'b1;
              state_q           <= ret_state;
            end
          end
        end
        StFlush: begin
          if (fl_stop) begin
            state_q <= StClose;
          end else begin
            if (pend_vld_q[fl_q]) begin
              val_q            <= pend_val_q[fl_q];
              pend_vld_q[fl_q] <= 1'b0;
              lvl_q            <= fl_q + 1'b1;
              state_q          <= StInsert;
            end
            fl_q <= fl_q + 1'b1;
          end
        end
        StClose: begin
          if (ob_ready_i) begin
            state_q <= StIdle;
            if (end_q) begin
              pend_vld_q <= '0;
              for (int i = 0; i < MaxLevels; i++) begin
                cnt_q[i] <= '0;
              end
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      pend_val_q[lvl_q] <= val_q;
    end
  end

  assign ob_req_o.push  = (state_q == StInsert);
  assign ob_req_o.close = (state_q == StClose);
  assign ob_req_o.last  = end_q;

  assign res_o.level = LvlW'(lvl_q);
  assign res_o.index = cur_cnt;
  assign res_o.value = val_q;

  assign idle_o = (state_q == StIdle);
  assign done_o = (state_q == StClose) && ob_ready_i;

  `WPP_ASSERT_NXT(a_clip_end_clears, done_o && end_q, (pend_vld_q == '0) && (cnt_q[0] == '0))
  `WPP_ASSERT_IMP(a_no_start_when_busy, start_i, idle_o)

endmodule

`default_nettype wire

// File: hdl/wpp_outbuf.sv
// ----------------------------------------------------------------------------
// wpp_outbuf
// Hold stage plus output register: a word is released only once the next one
// or the close of the frame is known, so the final word carries its last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wpp_outbuf import wpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wpp_ob_req_t req_i,
  input  wpp_res_t    res_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output wpp_res_t    out_res_o,
  output logic        out_last_o
);

  logic     hold_vld_q;
  wpp_res_t hold_q;
  logic     out_vld_q;
  wpp_res_t out_q;
  logic     out_last_q;

  logic out_free;
  logic push;
  logic close;
  logic move;

  assign out_free = !out_vld_q || out_ready_i;
  assign ready_o  = !hold_vld_q || out_free;
  assign push     = req_i.push && ready_o;
  assign close    = req_i.close && ready_o;
  assign move     = hold_vld_q && (push || close);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (push) begin
        hold_vld_q <= 1'b1;
      end else if (close) begin
        hold_vld_q <= 1'b0;
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      hold_q <= res_i;
    end
    if (move) begin
      out_q      <= hold_q;
      out_last_q <= close && req_i.last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

  `WPP_ASSERT_NXT(a_move_fills_output, move, out_valid_o)
  `WPP_ASSERT_NXT(a_close_empties_hold, close, !hold_vld_q)

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for waveform_peak_pyramid. Frames go in over a
// valid/ready channel and a behavioural model of the peak pyramid predicts
// every output word: level, bucket index, companded peak and last flag. The
// run covers the default bucket size, sample extremes, bucket sizes of zero,
// one, 4096 and beyond, a bucket shrunk mid-way, random clips with random
// gaps on both sides, a long output stall and a bucket size above the maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wpp_pkg::*;

  localparam int unsigned SettleCycles = 100;
  localparam int unsigned MaxPrints    = 40;

  typedef struct packed {
    logic [LvlW-1:0] level;
    logic [IdxW-1:0] index;
    logic [ValW-1:0] value;
    logic            last;
  } peak_word_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgW-1:0]         cfg_bucket_frames_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [SampW-1:0] left_sample_i;
  logic signed [SampW-1:0] right_sample_i;
  logic                    end_of_clip_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [LvlW-1:0]         level_o;
  logic [IdxW-1:0]         bucket_index_o;
  logic [ValW-1:0]         peak_value_o;
  logic                    last_o;

  waveform_peak_pyramid i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_bucket_frames_i (cfg_bucket_frames_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .left_sample_i       (left_sample_i),
    .right_sample_i      (right_sample_i),
    .end_of_clip_i       (end_of_clip_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .level_o             (level_o),
    .bucket_index_o      (bucket_index_o),
    .peak_value_o        (peak_value_o),
    .last_o              (last_o)
  );

  // Pyramid model state
  logic [CfgW-1:0]  bucket_cfg;
  logic [MagW-1:0]  run_peak;
  int unsigned      frame_cnt;
  logic [ValW-1:0]  pend_val  [MaxLevels];
  logic             pend_ok   [MaxLevels];
  logic [IdxW-1:0]  level_cnt [MaxLevels];
  peak_word_t       peaks_due [$];

  int unsigned err_count;
  int unsigned frames_sent;
  int unsigned words_checked;
  bit          in_idle_en;
  bit          out_idle_en;
  int unsigned rx_hold;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic void clear_pyramid();
    run_peak  = '0;
    frame_cnt = 0;
    for (int i = 0; i < MaxLevels; i++) begin
      pend_val[i]  = '0;
      pend_ok[i]   = 1'b0;
      level_cnt[i] = '0;
    end
  endfunction

  function automatic logic [MagW-1:0] clip_mag(input logic [SampW-1:0] s);
    logic [SampW:0] m;
    m = s[SampW-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    return (m > 17'd32767) ? 15'h7fff : m[MagW-1:0];
  endfunction

  // round-half-up of 255 * sqrt(p / 32768)
  function automatic logic [ValW-1:0] sqrt_compand(input logic [MagW-1:0] p);
    longint unsigned rhs;
    longint unsigned odd;
    logic [ValW-1:0] v;
    rhs = 64'd65025 * longint'(p);
    v = '0;
    for (int n = 1; n <= 255; n++) begin
      odd = 2 * longint'(n) - 1;
      if (odd * odd * 8192 <= rhs) v = ValW'(n);
    end
    return v;
  endfunction

  function automatic void push_level(input int unsigned lvl, input logic [ValW-1:0] val);
    peak_word_t w;
    while (lvl < MaxLevels) begin
      w.level = LvlW'(lvl);
      w.index = level_cnt[lvl];
      w.value = val;
      w.last  = 1'b0;
      peaks_due.insert(peaks_due.size(), w);
      level_cnt[lvl] = level_cnt[lvl] + 1'b1;
      if (lvl + 1 >= MaxLevels) return;
      if (pend_ok[lvl]) begin
        if (pend_val[lvl] > val) val = pend_val[lvl];
        pend_ok[lvl]  = 1'b0;
        pend_val[lvl] = '0;
        lvl++;
      end else begin
        pend_val[lvl] = val;
        pend_ok[lvl]  = 1'b1;
        return;
      end
    end
  endfunction

  function automatic void predict_frame(input logic [SampW-1:0] l, input logic [SampW-1:0] r,
                                        input logic eoc);
    int unsigned     size;
    int unsigned     n0;
    logic [MagW-1:0] a;
    logic [MagW-1:0] b;
    logic [ValW-1:0] v;
    n0   = peaks_due.size();
    size = bucket_cfg;
    if (size == 0) size = 1;
    if (size > MaxBucketFrames) size = MaxBucketFrames;
    a = clip_mag(l);
    b = clip_mag(r);
    if (a > run_peak) run_peak = a;
    if (b > run_peak) run_peak = b;
    if (frame_cnt + 1 >= size || eoc) begin
      push_level(0, sqrt_compand(run_peak));
      run_peak  = '0;
      frame_cnt = 0;
    end else begin
      frame_cnt++;
    end
    if (eoc) begin
      for (int lv = 0; lv + 1 < MaxLevels; lv++) begin
        if (level_cnt[lv] <= 1) break;
        if (pend_ok[lv]) begin
          v            = pend_val[lv];
          pend_ok[lv]  = 1'b0;
          pend_val[lv] = '0;
          push_level(lv + 1, v);
        end
      end
      if (peaks_due.size() > n0) peaks_due[peaks_due.size() - 1].last = 1'b1;
      clear_pyramid();
    end
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (err_count < MaxPrints)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin : check_words
    peak_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (peaks_due.size() == 0) begin
        report_mismatch("unexpected word, level", level_o, 0);
      end else begin
        want = peaks_due.pop_front();
        if (level_o !== want.level) report_mismatch("level", level_o, want.level);
        if (bucket_index_o !== want.index) report_mismatch("bucket_index", bucket_index_o, want.index);
        if (peak_value_o !== want.value) report_mismatch("peak_value", peak_value_o, want.value);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  // Output side: random stalls per word, or one long hold when asked
  initial begin : drain_side
    int unsigned w;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      w = out_idle_en ? $urandom_range(0, 5) : 0;
      if (rx_hold != 0) begin
        w = rx_hold;
        rx_hold = 0;
      end
      @(negedge clk_i);
      if (w != 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_frame(input logic [SampW-1:0] l, input logic [SampW-1:0] r,
                            input logic eoc);
    int unsigned gap;
    gap = in_idle_en ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    end_of_clip_i  <= eoc;
    do @(posedge clk_i); while (!in_ready_o);
    predict_frame(l, r, eoc);
    frames_sent++;
  endtask

  // Drop valid, wait for every expected word, then let the block settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (peaks_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_bucket(input logic [CfgW-1:0] frames);
    @(negedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_bucket_frames_i <= frames;
    do @(posedge clk_i); while (!cfg_ready_o);
    bucket_cfg = frames;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SampW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return SampW'($urandom_range(0, 63));
      4:       return SampW'(-$urandom_range(1, 64));
      default: return SampW'($urandom());
    endcase
  endfunction

  task automatic test_default_bucket();
    send_frame(16'h0100, 16'hfe00, 1'b0);
    send_frame(16'h8000, 16'h0000, 1'b0);
    send_frame(16'h0000, 16'h0001, 1'b1);
    wait_idle();
  endtask

  task automatic test_sample_extremes();
    write_bucket(13'd1);
    send_frame(16'h8000, 16'h0000, 1'b0);
    send_frame(16'h7fff, 16'h8001, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(16'hffff, 16'h0001, 1'b0);
    send_frame(16'h2000, 16'h1fff, 1'b0);
    send_frame(16'h1fff, 16'h0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_bucket_zero();
    write_bucket(13'd0);
    send_frame(16'h0100, 16'hff00, 1'b0);
    send_frame(16'h7fff, 16'h0000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_bucket_shrink();
    write_bucket(13'd8);
    for (int i = 0; i < 5; i++) send_frame(pick_sample(), pick_sample(), 1'b0);
    wait_idle();
    write_bucket(13'd2);
    send_frame(pick_sample(), pick_sample(), 1'b0);
    send_frame(pick_sample(), pick_sample(), 1'b0);
    send_frame(pick_sample(), pick_sample(), 1'b1);
    wait_idle();
  endtask

  task automatic test_bucket_max();
    write_bucket(13'd4096);
    send_frame(16'h4000, 16'h0010, 1'b0);
    send_frame(16'h8000, 16'hc000, 1'b0);
    send_frame(16'h0001, 16'h0002, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_clips();
    int unsigned sizes [6];
    int unsigned left;
    int unsigned clip;
    sizes = '{1, 2, 3, 5, 0, 6};
    for (int ph = 0; ph < 6; ph++) begin
      write_bucket(CfgW'(sizes[ph]));
      in_idle_en  = (ph != 2);
      out_idle_en = (ph != 2);
      left = 10;
      while (left != 0) begin
        clip = $urandom_range(1, 9);
        if (clip > left) clip = left;
        for (int i = 0; i < clip; i++)
          send_frame(pick_sample(), pick_sample(), i == clip - 1);
        left -= clip;
      end
      wait_idle();
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  task automatic test_output_stall();
    write_bucket(13'd1);
    rx_hold = 250;
    for (int i = 0; i < 16; i++) send_frame(pick_sample(), pick_sample(), i == 15);
    wait_idle();
  endtask

  task automatic test_sender_pause();
    write_bucket(13'd2);
    for (int i = 0; i < 5; i++) send_frame(pick_sample(), pick_sample(), 1'b0);
    wait_idle();
    for (int i = 0; i < 5; i++) send_frame(pick_sample(), pick_sample(), i == 4);
    wait_idle();
  endtask

  task automatic test_bucket_oversize();
    write_bucket(13'h1fff);
    send_frame(pick_sample(), pick_sample(), 1'b0);
    send_frame(16'h8000, pick_sample(), 1'b0);
    send_frame(pick_sample(), pick_sample(), 1'b1);
    wait_idle();
  endtask

  initial begin : run_tests
    rst_ni              = 1'b0;
    cfg_valid_i         = 1'b0;
    cfg_bucket_frames_i = '0;
    in_valid_i          = 1'b0;
    left_sample_i       = '0;
    right_sample_i      = '0;
    end_of_clip_i       = 1'b0;
    err_count           = 0;
    frames_sent         = 0;
    words_checked       = 0;
    in_idle_en          = 1'b1;
    out_idle_en         = 1'b1;
    rx_hold             = 0;
    bucket_cfg          = BucketReset;
    clear_pyramid();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_bucket();
    test_sample_extremes();
    test_bucket_zero();
    test_bucket_shrink();
    test_bucket_max();
    test_random_clips();
    test_output_stall();
    test_sender_pause();
    test_bucket_oversize();

    $display("covered %0d frames and %0d peak words", frames_sent, words_checked);
    $display("bucket sizes 0, 1, 2, 3, 5, 6, 8, 512, 4096 and 8191, with long output stall");
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
